// File: rtl/core/bhrul_pkg.sv
package bhrul_pkg;

    localparam int CYCLE_W   = 16;
    localparam int CAP_W     = 16;
    localparam int TEMP_W    = 12;
    localparam int SOC_W     = 14;
    localparam int SOH_W     = 16;
    localparam int THR_W     = 14;
    localparam int RUL_W     = 11;
    localparam int PROD_W    = 30;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int STEP_W    = 5;

    localparam logic [CFG_IDX_W-1:0] REG_WARNING_TEMP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_TEMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTRICTED_SOH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_SOH   = 3'd3;

    localparam logic signed [TEMP_W-1:0] WARNING_TEMP_RST  = 12'sd450;
    localparam logic signed [TEMP_W-1:0] CRITICAL_TEMP_RST = 12'sd600;
    localparam logic [THR_W-1:0]         RESTRICTED_RST    = 14'd8000;
    localparam logic [THR_W-1:0]         CRITICAL_RST      = 14'd6500;

    localparam logic [THR_W-1:0]  SOH_SCALE       = 14'd10000;
    localparam logic [SOH_W-1:0]  SOH_FULL        = 16'd10000;
    localparam logic [SOH_W-1:0]  SOH_POOR        = 16'd7000;
    localparam logic [SOH_W-1:0]  SOH_SAT         = 16'hFFFF;
    localparam logic [SOH_W-1:0]  MIN_DEGRADATION = 16'd50;
    localparam logic [RUL_W-1:0]  RUL_CAP         = 11'd1000;
    localparam logic [RUL_W-1:0]  RUL_NONE        = 11'h7FF;
    localparam logic [RUL_W-1:0]  RUL_ZERO        = 11'd0;

    localparam logic [STEP_W-1:0] SOH_QBITS = 5'd16;
    localparam logic [STEP_W-1:0] RUL_QBITS = 5'd10;

    localparam logic [1:0] THERM_COLD     = 2'd0;
    localparam logic [1:0] THERM_NORMAL   = 2'd1;
    localparam logic [1:0] THERM_WARNING  = 2'd2;
    localparam logic [1:0] THERM_CRITICAL = 2'd3;

    localparam logic [1:0] HEALTH_GOOD     = 2'd0;
    localparam logic [1:0] HEALTH_DEGRADED = 2'd1;
    localparam logic [1:0] HEALTH_POOR     = 2'd2;
    localparam logic [1:0] HEALTH_CRITICAL = 2'd3;

    typedef logic [CYCLE_W+SOH_W-1:0] window_entry_t;

endpackage

// File: rtl/core/battery_health_rul_evaluator_top.sv
// channel   direction  handshake               payload
// in        input      in_valid / in_stall     cycle_number, capacity, avg_temp, soc_estimate
// out       output     out_valid / out_stall   cycle_echo .. health_grade
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// a result appears when its item is done, and in_stall falls with it; both quotients come from the
// shared radix-2 divider, 16 steps for state of health and 10 for life
// reset clears the registers, the rated capacity latch and the window pointers
// in_stall is high while an item is at work; a waiting result does not block the next item
// a finished item waits for out_stall to fall only if the previous result is still held
module battery_health_rul_evaluator_top #(
    parameter int WINDOW_DEPTH = 50
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [bhrul_pkg::CYCLE_W-1:0]         cycle_number,
    input  logic [bhrul_pkg::CAP_W-1:0]           capacity,
    input  logic signed [bhrul_pkg::TEMP_W-1:0]   avg_temp,
    input  logic [bhrul_pkg::SOC_W-1:0]           soc_estimate,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [bhrul_pkg::CYCLE_W-1:0]         cycle_echo,
    output logic [bhrul_pkg::SOH_W-1:0]           soh_hundredths,
    output logic [bhrul_pkg::SOC_W-1:0]           soc_out,
    output logic [1:0]                            thermal_state,
    output logic                                  power_restricted,
    output logic                                  soh_critical,
    output logic signed [bhrul_pkg::RUL_W-1:0]    rul_cycles,
    output logic [1:0]                            health_grade,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bhrul_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bhrul_pkg::CFG_DAT_W-1:0]       cfg_data
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(WINDOW_DEPTH);
    localparam logic [CW-1:0] TWO_CNT   = CW'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_POST,
        ST_FIN
    } state_t;

    bhrul_pkg::window_entry_t window_mem [WINDOW_DEPTH];

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    logic signed [bhrul_pkg::TEMP_W-1:0] warn_reg, warn_next;
    logic signed [bhrul_pkg::TEMP_W-1:0] hot_reg, hot_next;
    logic [bhrul_pkg::THR_W-1:0]         restr_reg, restr_next;
    logic [bhrul_pkg::THR_W-1:0]         crit_reg, crit_next;

    logic [bhrul_pkg::CAP_W-1:0] rated_reg, rated_next;
    logic                        latched_reg, latched_next;
    logic [AW-1:0]               head_reg, head_next;
    logic [CW-1:0]               count_reg, count_next;

    logic [bhrul_pkg::CYCLE_W-1:0]       cyc_reg, cyc_next;
    logic [bhrul_pkg::CAP_W-1:0]         cap_reg, cap_next;
    logic signed [bhrul_pkg::TEMP_W-1:0] temp_reg, temp_next;
    logic [bhrul_pkg::SOC_W-1:0]         soc_reg, soc_next;

    logic [bhrul_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [15:0]                  rem_reg, rem_next;
    logic [bhrul_pkg::PROD_W-1:0] num_reg, num_next;
    logic [15:0]                  q_reg, q_next;
    logic [15:0]                  dvsr_reg, dvsr_next;
    logic [bhrul_pkg::STEP_W-1:0] step_reg, step_next;

    logic [bhrul_pkg::SOH_W-1:0]   soh_reg, soh_next;
    logic [1:0]                    therm_reg, therm_next;
    logic                          restr_flag_reg, restr_flag_next;
    logic                          crit_flag_reg, crit_flag_next;
    logic [1:0]                    health_reg, health_next;
    logic [bhrul_pkg::THR_W-1:0]   margin_reg, margin_next;
    logic [bhrul_pkg::CYCLE_W-1:0] cspan_reg, cspan_next;
    logic [bhrul_pkg::SOH_W-1:0]   sspan_reg, sspan_next;
    logic [bhrul_pkg::RUL_W-1:0]   rul_reg, rul_next;

    logic                                out_valid_reg, out_valid_next;
    logic [bhrul_pkg::CYCLE_W-1:0]       o_cyc_reg, o_cyc_next;
    logic [bhrul_pkg::SOH_W-1:0]         o_soh_reg, o_soh_next;
    logic [bhrul_pkg::SOC_W-1:0]         o_soc_reg, o_soc_next;
    logic [1:0]                          o_therm_reg, o_therm_next;
    logic                                o_restr_reg, o_restr_next;
    logic                                o_crit_reg, o_crit_next;
    logic [bhrul_pkg::RUL_W-1:0]         o_rul_reg, o_rul_next;
    logic [1:0]                          o_health_reg, o_health_next;

    bhrul_pkg::window_entry_t rd_data_reg;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    bhrul_pkg::window_entry_t wr_data;

    logic [AW-1:0] head_inc;
    logic [CW-1:0] count_inc;

    logic [15:0]                  mul_a;
    logic [bhrul_pkg::THR_W-1:0]  mul_b;
    logic [bhrul_pkg::PROD_W-1:0] mul_p;

    logic [16:0] trial;
    logic        trial_ge;
    logic [15:0] q_step;

    logic [bhrul_pkg::CYCLE_W-1:0] old_cycle;
    logic [bhrul_pkg::SOH_W-1:0]   old_soh;
    logic [16:0]                   cspan_w;
    logic [16:0]                   sspan_w;
    logic [16:0]                   margin_w;
    logic                          rul_ok;
    logic [1:0]                    therm_w;
    logic                          restr_w;
    logic                          crit_w;

    assign head_inc  = (head_reg == LAST_ADDR) ? '0 : head_reg + AW'(1);
    assign count_inc = (count_reg < DEPTH_CNT) ? count_reg + CW'(1) : count_reg;

    // shared multiplier
    assign mul_a = phase_reg ? cspan_reg : cap_reg;
    assign mul_b = phase_reg ? margin_reg : bhrul_pkg::SOH_SCALE;
    assign mul_p = bhrul_pkg::PROD_W'(mul_a) * bhrul_pkg::PROD_W'(mul_b);

    // one restoring division step
    assign trial    = {rem_reg, num_reg[bhrul_pkg::PROD_W-1]};
    assign trial_ge = trial >= {1'b0, dvsr_reg};
    assign q_step   = {q_reg[14:0], trial_ge};

    assign old_cycle = rd_data_reg[bhrul_pkg::CYCLE_W+bhrul_pkg::SOH_W-1:bhrul_pkg::SOH_W];
    assign old_soh   = rd_data_reg[bhrul_pkg::SOH_W-1:0];
    assign cspan_w   = {1'b0, cyc_reg} - {1'b0, old_cycle};
    assign sspan_w   = {1'b0, old_soh} - {1'b0, q_reg};
    assign margin_w  = {1'b0, q_reg} - {3'b0, restr_reg};
    assign rul_ok    = (count_inc >= TWO_CNT) && (q_reg < bhrul_pkg::SOH_FULL)
                       && !cspan_w[16] && (cspan_w != '0)
                       && !sspan_w[16] && (sspan_w[15:0] > bhrul_pkg::MIN_DEGRADATION);

    always_comb
    begin
        if (temp_reg < 0)
            therm_w = bhrul_pkg::THERM_COLD;
        else if (temp_reg <= warn_reg)
            therm_w = bhrul_pkg::THERM_NORMAL;
        else if (temp_reg <= hot_reg)
            therm_w = bhrul_pkg::THERM_WARNING;
        else
            therm_w = bhrul_pkg::THERM_CRITICAL;
    end

    assign restr_w = q_reg < {2'b0, restr_reg};
    assign crit_w  = q_reg < {2'b0, crit_reg};

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        warn_next       = warn_reg;
        hot_next        = hot_reg;
        restr_next      = restr_reg;
        crit_next       = crit_reg;
        rated_next      = rated_reg;
        latched_next    = latched_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        cyc_next        = cyc_reg;
        cap_next        = cap_reg;
        temp_next       = temp_reg;
        soc_next        = soc_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        num_next        = num_reg;
        q_next          = q_reg;
        dvsr_next       = dvsr_reg;
        step_next       = step_reg;
        soh_next        = soh_reg;
        therm_next      = therm_reg;
        restr_flag_next = restr_flag_reg;
        crit_flag_next  = crit_flag_reg;
        health_next     = health_reg;
        margin_next     = margin_reg;
        cspan_next      = cspan_reg;
        sspan_next      = sspan_reg;
        rul_next        = rul_reg;
        out_valid_next  = out_valid_reg;
        o_cyc_next      = o_cyc_reg;
        o_soh_next      = o_soh_reg;
        o_soc_next      = o_soc_reg;
        o_therm_next    = o_therm_reg;
        o_restr_next    = o_restr_reg;
        o_crit_next     = o_crit_reg;
        o_rul_next      = o_rul_reg;
        o_health_next   = o_health_reg;
        rd_en           = 1'b0;
        rd_addr         = (count_inc < DEPTH_CNT) ? '0 : head_inc;
        wr_en           = 1'b0;
        wr_data         = {cyc_reg, q_reg};

        if (cfg_valid)
        begin
            unique case (cfg_index)
                bhrul_pkg::REG_WARNING_TEMP:
                    warn_next = signed'(cfg_data[bhrul_pkg::TEMP_W-1:0]);
                bhrul_pkg::REG_CRITICAL_TEMP:
                    hot_next = signed'(cfg_data[bhrul_pkg::TEMP_W-1:0]);
                bhrul_pkg::REG_RESTRICTED_SOH:
                    restr_next = cfg_data[bhrul_pkg::THR_W-1:0];
                bhrul_pkg::REG_CRITICAL_SOH:
                    crit_next = cfg_data[bhrul_pkg::THR_W-1:0];
                default:
                    ;
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cyc_next   = cycle_number;
                    cap_next   = capacity;
                    temp_next  = avg_temp;
                    soc_next   = soc_estimate;
                    phase_next = 1'b0;
                    if (!latched_reg)
                    begin
                        rated_next   = capacity;
                        latched_next = 1'b1;
                    end
                    rd_en      = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                q_next = '0;
                if (!phase_reg)
                begin
                    dvsr_next = rated_reg;
                    step_next = bhrul_pkg::SOH_QBITS;
                    rem_next  = {2'b0, prod_reg[29:16]};
                    num_next  = {prod_reg[15:0], 14'b0};
                    if (rated_reg == '0 || {2'b0, prod_reg} >= {rated_reg, 16'b0})
                    begin
                        q_next     = bhrul_pkg::SOH_SAT;
                        state_next = ST_POST;
                    end
                    else
                        state_next = ST_DIV;
                end
                else
                begin
                    dvsr_next = sspan_reg;
                    step_next = bhrul_pkg::RUL_QBITS;
                    rem_next  = prod_reg[25:10];
                    num_next  = {prod_reg[9:0], 20'b0};
                    if (prod_reg >= {4'b0, sspan_reg, 10'b0})
                    begin
                        rul_next   = bhrul_pkg::RUL_CAP;
                        state_next = ST_FIN;
                    end
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = trial_ge ? 16'(trial - {1'b0, dvsr_reg}) : trial[15:0];
                num_next  = {num_reg[bhrul_pkg::PROD_W-2:0], 1'b0};
                q_next    = q_step;
                step_next = step_reg - bhrul_pkg::STEP_W'(1);
                if (step_reg == bhrul_pkg::STEP_W'(1))
                begin
                    if (!phase_reg)
                        state_next = ST_POST;
                    else
                    begin
                        rul_next   = (q_step[10:0] > bhrul_pkg::RUL_CAP)
                                     ? bhrul_pkg::RUL_CAP : q_step[10:0];
                        state_next = ST_FIN;
                    end
                end
            end
            ST_POST:
            begin
                soh_next        = q_reg;
                therm_next      = therm_w;
                restr_flag_next = restr_w;
                crit_flag_next  = crit_w;
                if (crit_w || therm_w == bhrul_pkg::THERM_CRITICAL)
                    health_next = bhrul_pkg::HEALTH_CRITICAL;
                else if (q_reg < bhrul_pkg::SOH_POOR || therm_w == bhrul_pkg::THERM_WARNING)
                    health_next = bhrul_pkg::HEALTH_POOR;
                else if (restr_w)
                    health_next = bhrul_pkg::HEALTH_DEGRADED;
                else
                    health_next = bhrul_pkg::HEALTH_GOOD;

                wr_en      = 1'b1;
                head_next  = head_inc;
                count_next = count_inc;

                margin_next = margin_w[bhrul_pkg::THR_W-1:0];
                cspan_next  = cspan_w[15:0];
                sspan_next  = sspan_w[15:0];
                phase_next  = 1'b1;
                if (!rul_ok)
                begin
                    rul_next   = bhrul_pkg::RUL_NONE;
                    state_next = ST_FIN;
                end
                else if (margin_w[16] || margin_w == '0)
                begin
                    rul_next   = bhrul_pkg::RUL_ZERO;
                    state_next = ST_FIN;
                end
                else
                    state_next = ST_MUL;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_cyc_next     = cyc_reg;
                    o_soh_next     = soh_reg;
                    o_soc_next     = soc_reg;
                    o_therm_next   = therm_reg;
                    o_restr_next   = restr_flag_reg;
                    o_crit_next    = crit_flag_reg;
                    o_rul_next     = rul_reg;
                    o_health_next  = health_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // window store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            window_mem[head_reg] <= wr_data;
        if (rd_en)
            rd_data_reg <= window_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= 1'b0;
            warn_reg       <= bhrul_pkg::WARNING_TEMP_RST;
            hot_reg        <= bhrul_pkg::CRITICAL_TEMP_RST;
            restr_reg      <= bhrul_pkg::RESTRICTED_RST;
            crit_reg       <= bhrul_pkg::CRITICAL_RST;
            rated_reg      <= '0;
            latched_reg    <= 1'b0;
            head_reg       <= '0;
            count_reg      <= '0;
            cyc_reg        <= '0;
            cap_reg        <= '0;
            temp_reg       <= '0;
            soc_reg        <= '0;
            prod_reg       <= '0;
            rem_reg        <= '0;
            num_reg        <= '0;
            q_reg          <= '0;
            dvsr_reg       <= '0;
            step_reg       <= '0;
            soh_reg        <= '0;
            therm_reg      <= '0;
            restr_flag_reg <= 1'b0;
            crit_flag_reg  <= 1'b0;
            health_reg     <= '0;
            margin_reg     <= '0;
            cspan_reg      <= '0;
            sspan_reg      <= '0;
            rul_reg        <= '0;
            out_valid_reg  <= 1'b0;
            o_cyc_reg      <= '0;
            o_soh_reg      <= '0;
            o_soc_reg      <= '0;
            o_therm_reg    <= '0;
            o_restr_reg    <= 1'b0;
            o_crit_reg     <= 1'b0;
            o_rul_reg      <= '0;
            o_health_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            warn_reg       <= warn_next;
            hot_reg        <= hot_next;
            restr_reg      <= restr_next;
            crit_reg       <= crit_next;
            rated_reg      <= rated_next;
            latched_reg    <= latched_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            cyc_reg        <= cyc_next;
            cap_reg        <= cap_next;
            temp_reg       <= temp_next;
            soc_reg        <= soc_next;
            prod_reg       <= prod_next;
            rem_reg        <= rem_next;
            num_reg        <= num_next;
            q_reg          <= q_next;
            dvsr_reg       <= dvsr_next;
            step_reg       <= step_next;
            soh_reg        <= soh_next;
            therm_reg      <= therm_next;
            restr_flag_reg <= restr_flag_next;
            crit_flag_reg  <= crit_flag_next;
            health_reg     <= health_next;
            margin_reg     <= margin_next;
            cspan_reg      <= cspan_next;
            sspan_reg      <= sspan_next;
            rul_reg        <= rul_next;
            out_valid_reg  <= out_valid_next;
            o_cyc_reg      <= o_cyc_next;
            o_soh_reg      <= o_soh_next;
            o_soc_reg      <= o_soc_next;
            o_therm_reg    <= o_therm_next;
            o_restr_reg    <= o_restr_next;
            o_crit_reg     <= o_crit_next;
            o_rul_reg      <= o_rul_next;
            o_health_reg   <= o_health_next;
        end
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign cycle_echo       = o_cyc_reg;
    assign soh_hundredths   = o_soh_reg;
    assign soc_out          = o_soc_reg;
    assign thermal_state    = o_therm_reg;
    assign power_restricted = o_restr_reg;
    assign soh_critical     = o_crit_reg;
    assign rul_cycles       = signed'(o_rul_reg);
    assign health_grade     = o_health_reg;

endmodule
